### design/lbt_pkg.sv
// Package for the LRU byte-budget texture table: command codes, cell bus types.
// No dependencies.
`default_nettype none
package lbt_pkg;
  typedef enum logic [3:0] {
    CMD_REQUEST = 4'd0, CMD_RELEASE = 4'd1, CMD_HAS = 4'd2, CMD_IS_PROT = 4'd3,
    CMD_PROTECT = 4'd4, CMD_UNPROTECT = 4'd5, CMD_UNPROT_ALL = 4'd6, CMD_TRIM = 4'd7,
    CMD_GET_TOKEN = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOK, ST_EVICT, ST_CHECK, ST_FULL, ST_INSERT, ST_NOTE, ST_ANSWER
  } state_t;

  localparam int unsigned REG_MEMORY_LIMIT = 0;
  localparam int unsigned REG_MAX_TEX = 1;

  // Broadcast from the controller to all cells.
  typedef struct packed {
    logic [31:0] key;       // key to match
    logic        drop_hit;  // remove the entry matching key
    logic        touch_hit; // move matching entry to most recent
    logic        pin_hit;
    logic        unpin_hit;
    logic        unpin_all;
    logic        evict_old; // remove the oldest unpinned entry
    logic        insert;    // first free cell takes key/bytes
    logic [30:0] bytes;
  } cell_cmd_t;
endpackage
`default_nettype wire

### design/lru_budget_texture_table_top.sv
// Top level of the LRU byte-budget texture table: controller over a chain of cells.
// Depends on lbt_pkg and lbt_cell.
// One command is held at a time; the input stalls until its answer is taken.
// A plain command passes through lookup, answer set-up, the answer item and the
// idle state before the next acceptance. A request adds a budget check, the
// eviction test, the full-table test and the insert. Each eviction costs a
// search over recency ranks, one rank a cycle from the least recent up to the
// oldest unpinned entry, then its removal and the hand-out of its notice item.
// A dropped old entry costs only its notice. Pinned entries at the old end
// lengthen every search. Each removal emits one notice item, then one final
// answer item with last set. Output stalls hold it in the answer state.
`default_nettype none
module lru_budget_texture_table_top #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  command,
  input  wire logic [31:0] token,
  input  wire logic [15:0] width,
  input  wire logic [15:0] height,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             result_kind,
  output logic [31:0]      evicted_token,
  output logic             answer,
  output logic [31:0]      new_token,
  output logic [35:0]      memory_used,
  output logic             last
);
  localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [31:0] memory_limit;
  logic [14:0] max_tex;
  logic [35:0] used;
  logic [31:0] tok_ctr;
  logic [3:0]  cmd_r;
  logic [31:0] tok_r;
  logic [15:0] w_r, h_r;
  logic [31:0] prod;       // w*h, registered
  logic [33:0] req;        // byte cost
  logic        ans;
  logic [35:0] target;     // evict while used > target
  logic        req_mode;   // evicting on behalf of a request
  logic [RW-1:0] scan;     // rank being searched
  logic [31:0] note_key;
  logic [30:0] note_bytes;
  lbt_pkg::state_t state, state_next;

  // Notice queue: keys noted by removals, drained before the answer.
  logic [31:0] q [ENTRIES+1];
  logic [RW+1:0] q_wr, q_rd;

  lbt_pkg::cell_cmd_t ccmd;
  logic [RW:0] count;
  logic rm_act, tch_act;
  logic [RW-1:0] rm_rank, tch_rank;
  logic [ENTRIES:0] free_c, old_c;
  logic [ENTRIES-1:0] v_v, h_v, p_v, c_v;
  logic [RW-1:0] r_v [ENTRIES];
  logic [31:0] k_v [ENTRIES];
  logic [30:0] b_v [ENTRIES];

  assign free_c[0] = 1'b0;
  assign old_c[0]  = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lbt_cell #(.RW(RW)) u_cell (
      .clk, .rst, .cmd(ccmd), .count, .rm_rank, .rm_act, .tch_rank, .tch_act,
      .free_in(free_c[g]), .free_out(free_c[g+1]),
      .old_in(old_c[g]), .old_out(old_c[g+1]),
      .valid(v_v[g]), .hit(h_v[g]), .pinned(p_v[g]), .cand(c_v[g]),
      .rank(r_v[g]), .key(k_v[g]), .bytes(b_v[g]));
  end

  // Hit and oldest-at-scan lookups (one hit at most; mux by OR).
  logic any_hit, hit_pin, any_cand, scan_hit;
  logic [RW-1:0] hit_rank;
  logic [31:0] scan_key;
  logic [30:0] hit_bytes, scan_bytes;
  always_comb begin
    any_hit = 1'b0; hit_pin = 1'b0; hit_rank = '0; hit_bytes = '0;
    scan_hit = 1'b0; scan_key = '0; scan_bytes = '0;
    count = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      count = count + (RW+1)'(v_v[i]);
      if (h_v[i] && tok_r != 32'd0) begin
        any_hit = 1'b1; hit_pin |= p_v[i]; hit_rank |= r_v[i]; hit_bytes |= b_v[i];
      end
      if (c_v[i] && r_v[i] == scan) begin
        scan_hit = 1'b1; scan_key |= k_v[i]; scan_bytes |= b_v[i];
      end
    end
    any_cand = |c_v;
  end

  assign in_stall = (state != lbt_pkg::ST_IDLE);
  logic fits, full;
  assign fits = ({2'b00, used} + {4'b0, req}) <= {6'b0, memory_limit};
  assign full = (count == (RW+1)'(ENTRIES));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      lbt_pkg::ST_IDLE:  if (in_valid) state_next = lbt_pkg::ST_LOOK;
      lbt_pkg::ST_LOOK: begin
        if (cmd_r == lbt_pkg::CMD_REQUEST) begin
          if (tok_r == 0 || w_r > {1'b0, max_tex} || h_r > {1'b0, max_tex})
            state_next = lbt_pkg::ST_ANSWER;
          else state_next = lbt_pkg::ST_CHECK;
        end else if (cmd_r == lbt_pkg::CMD_TRIM) state_next = lbt_pkg::ST_EVICT;
        else state_next = lbt_pkg::ST_ANSWER;
      end
      lbt_pkg::ST_CHECK: begin
        if ({2'b0, req} > {4'b0, memory_limit}) state_next = lbt_pkg::ST_ANSWER;
        else state_next = lbt_pkg::ST_EVICT;
      end
      lbt_pkg::ST_EVICT: begin
        if (used <= target || !any_cand)
          state_next = req_mode ? lbt_pkg::ST_FULL : lbt_pkg::ST_ANSWER;
        else if (scan_hit) state_next = lbt_pkg::ST_NOTE;
      end
      lbt_pkg::ST_NOTE: state_next = lbt_pkg::ST_EVICT;
      lbt_pkg::ST_FULL: begin
        if (!fits) state_next = lbt_pkg::ST_ANSWER;
        else if (full && !any_cand) state_next = lbt_pkg::ST_ANSWER;
        else if (full && scan_hit) state_next = lbt_pkg::ST_INSERT;
        else if (!full) state_next = lbt_pkg::ST_INSERT;
      end
      lbt_pkg::ST_INSERT: state_next = (full) ? lbt_pkg::ST_INSERT : lbt_pkg::ST_ANSWER;
      lbt_pkg::ST_ANSWER:
        if (q_rd == q_wr && out_valid && !out_stall) state_next = lbt_pkg::ST_IDLE;
      default: state_next = lbt_pkg::ST_IDLE;
    endcase
  end

  // Cell commands.
  always_comb begin
    ccmd = '0;
    ccmd.key = tok_r;
    ccmd.bytes = req[30:0];
    rm_act = 1'b0; rm_rank = scan; tch_act = 1'b0; tch_rank = hit_rank;
    case (state)
      lbt_pkg::ST_LOOK: begin
        if (any_hit) begin
          case (cmd_r)
            lbt_pkg::CMD_REQUEST:
              if (w_r <= {1'b0, max_tex} && h_r <= {1'b0, max_tex}) begin
                ccmd.drop_hit = 1'b1; rm_act = 1'b1; rm_rank = hit_rank;
              end
            lbt_pkg::CMD_RELEASE: begin
              ccmd.drop_hit = 1'b1; rm_act = 1'b1; rm_rank = hit_rank;
            end
            lbt_pkg::CMD_HAS, lbt_pkg::CMD_IS_PROT: begin
              ccmd.touch_hit = 1'b1; tch_act = 1'b1;
            end
            lbt_pkg::CMD_PROTECT:   ccmd.pin_hit = 1'b1;
            lbt_pkg::CMD_UNPROTECT: ccmd.unpin_hit = 1'b1;
            default: ;
          endcase
        end
        if (cmd_r == lbt_pkg::CMD_UNPROT_ALL) ccmd.unpin_all = 1'b1;
      end
      lbt_pkg::ST_NOTE: begin
        ccmd.evict_old = 1'b1; rm_act = 1'b1;
      end
      lbt_pkg::ST_INSERT: begin
        if (full) begin
          ccmd.evict_old = 1'b1; rm_act = 1'b1;
        end else ccmd.insert = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbt_pkg::ST_IDLE;
      memory_limit <= 32'd67108864;
      max_tex <= 15'd4096;
      used <= '0;
      tok_ctr <= 32'd1;
      out_valid <= 1'b0;
      q_wr <= '0; q_rd <= '0;
      scan <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == 1'(lbt_pkg::REG_MEMORY_LIMIT)) memory_limit <= cfg_data;
        else max_tex <= cfg_data[14:0];
      end
      case (state)
        lbt_pkg::ST_IDLE: begin
          q_wr <= '0; q_rd <= '0; scan <= '0;
          if (in_valid) begin
            cmd_r <= command; tok_r <= token; w_r <= width; h_r <= height;
            prod <= 32'(width * height);
            ans <= 1'b0; req_mode <= (command == lbt_pkg::CMD_REQUEST);
            target <= {4'b0, memory_limit};
          end
        end
        lbt_pkg::ST_LOOK: begin
          req <= {prod, 2'b00};
          if (rm_act) begin
            used <= used - {5'b0, hit_bytes};
            q[q_wr[RW:0]] <= tok_r; q_wr <= q_wr + 1'b1;
          end
          if (cmd_r == lbt_pkg::CMD_HAS && any_hit) ans <= 1'b1;
          if (cmd_r == lbt_pkg::CMD_IS_PROT && any_hit) ans <= hit_pin;
          if (cmd_r == lbt_pkg::CMD_GET_TOKEN) begin
            tok_ctr <= (tok_ctr == 32'hFFFF_FFFF) ? 32'd1 : tok_ctr + 1'b1;
          end
        end
        lbt_pkg::ST_CHECK: target <= {4'b0, memory_limit} - {2'b0, req};
        lbt_pkg::ST_EVICT: begin
          if (used <= target || !any_cand) scan <= '0;
          else if (scan_hit) begin
            note_key <= scan_key; note_bytes <= scan_bytes;
          end else scan <= scan + 1'b1;
        end
        lbt_pkg::ST_NOTE: begin
          used <= used - {5'b0, note_bytes};
          q[q_wr[RW:0]] <= note_key; q_wr <= q_wr + 1'b1;
          scan <= '0;
        end
        lbt_pkg::ST_FULL: begin
          if (full && any_cand && !scan_hit) scan <= scan + 1'b1;
          if (full && scan_hit) begin
            note_key <= scan_key; note_bytes <= scan_bytes;
          end
        end
        lbt_pkg::ST_INSERT: begin
          if (full) begin
            used <= used - {5'b0, scan_bytes};
            q[q_wr[RW:0]] <= scan_key; q_wr <= q_wr + 1'b1;
          end else begin
            used <= used + {2'b0, req};
            ans <= 1'b1;
          end
        end
        lbt_pkg::ST_ANSWER: begin
          if (!out_valid || !out_stall) begin
            if (out_valid && !last) q_rd <= q_rd + 1'b1;
            out_valid <= !(out_valid && last);
          end
        end
        default: ;
      endcase
    end
  end

  // Output item: notices from the queue, then the answer.
  logic [31:0] newtok_r;
  always_ff @(posedge clk) begin
    if (state == lbt_pkg::ST_LOOK)
      newtok_r <= (cmd_r == lbt_pkg::CMD_GET_TOKEN) ? tok_ctr : 32'd0;
  end

  logic [RW+1:0] cur;
  assign cur = q_rd;
  assign last = (cur == q_wr);
  assign result_kind = last;
  assign evicted_token = last ? 32'd0 : q[cur[RW:0]];
  assign answer = last ? ans : 1'b0;
  assign new_token = last ? newtok_r : 32'd0;
  assign memory_used = used;
endmodule
`default_nettype wire

### design/lbt_cell.sv
// One table entry with its rank; passes a "free seen" and "oldest candidate"
// token along the chain. Depends on lbt_pkg.
`default_nettype none
module lbt_cell #(
  parameter int unsigned RW = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lbt_pkg::cell_cmd_t cmd,
  input  wire logic [RW:0]      count,     // valid entries before this step
  input  wire logic [RW-1:0]    rm_rank,   // rank of the entry being removed
  input  wire logic             rm_act,    // a removal happens this cycle
  input  wire logic [RW-1:0]    tch_rank,
  input  wire logic             tch_act,
  input  wire logic             free_in,   // an earlier cell is free
  output logic                  free_out,
  input  wire logic             old_in,    // an earlier cell is the oldest unpinned
  output logic                  old_out,
  output logic                  valid,
  output logic                  hit,
  output logic                  pinned,
  output logic                  cand,      // unpinned and valid
  output logic [RW-1:0]         rank,
  output logic [31:0]           key,
  output logic [30:0]           bytes
);
  logic take, me_old;
  assign hit      = valid && (key == cmd.key);
  assign cand     = valid && !pinned;
  assign me_old   = cand && (rank == rm_rank) && !old_in;
  assign old_out  = old_in || me_old;
  assign take     = !valid && !free_in;
  assign free_out = free_in || !valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      pinned <= 1'b0;
    end else begin
      if ((cmd.drop_hit && hit) || (cmd.evict_old && me_old)) begin
        valid  <= 1'b0;
        pinned <= 1'b0;
      end else if (cmd.insert && take) begin
        valid  <= 1'b1;
        pinned <= 1'b1;
        key    <= cmd.key;
        bytes  <= cmd.bytes;
        rank   <= count[RW-1:0];
      end else if (valid) begin
        if (cmd.unpin_all || (cmd.unpin_hit && hit)) pinned <= 1'b0;
        else if (cmd.pin_hit && hit) pinned <= 1'b1;
        if (cmd.touch_hit && hit) rank <= RW'(count - 1'b1);
        else if (rm_act && rank > rm_rank) rank <= rank - 1'b1;
        else if (tch_act && rank > tch_rank) rank <= rank - 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

### design/lbt_checker.sv
// Port-level checks for the texture table top level, bound to it.
// Depends on lru_budget_texture_table_top ports only.
`default_nettype none
module lbt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        result_kind,
  input wire logic        last,
  input wire logic [35:0] memory_used
);
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind == last)) else $error("kind and last disagree");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while results pending");
  a_mem: assert property (@(posedge clk) disable iff (rst)
    (out_valid && $past(out_valid) && !$past(rst)) |-> $stable(memory_used))
    else $error("memory_used changed within a command");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
endmodule

bind lru_budget_texture_table_top lbt_checker u_lbt_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .result_kind, .last,
  .memory_used);
`default_nettype wire
